### rtl/spc_pkg.sv
`timescale 1ns / 1ps

package spc_pkg;

    localparam int SPC_MAX_LEN = 4096;
    localparam int CHAR_W      = 8;
    localparam int COUNT_W     = 13;
    localparam logic [CHAR_W-1:0] SEPARATOR = 8'd7;

    // controller -> datapath
    typedef struct packed {
        logic load;       // accepted input word: store byte, bump length
        logic init;       // start a pass: clear match length, q = 1, table[0] = 0
        logic save_back;  // keep the first pass result as the back count
        logic fetch;      // read symbols at q and at the match length
        logic compare;    // resolve one step of the prefix function
        logic emit;       // load the result register
        logic rev_first;  // pass reads reverse(s), separator, s
    } spc_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic too_long;   // the word being offered makes the string overflow
        logic backtrack;  // mismatch with a nonzero match length
        logic last_step;  // q is the final symbol of the sequence
        logic out_free;   // result register can take a new result
    } spc_status_t;

endpackage

### rtl/spc_ctrl.sv
`timescale 1ns / 1ps

module spc_ctrl
    import spc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        last_char,
    output logic        in_stall,
    input  spc_status_t status,
    output spc_cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_INIT  = 5'b00010,
        S_FETCH = 5'b00100,
        S_CMP   = 5'b01000,
        S_EMIT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   pass_reg, pass_next;
    logic   accept;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        state_next    = state_reg;
        pass_next     = pass_reg;
        cmd           = '0;
        cmd.rev_first = !pass_reg;
        cmd.load      = accept;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && last_char)
                begin
                    pass_next  = 1'b0;
                    state_next = status.too_long ? S_EMIT : S_INIT;
                end
            end
            S_INIT:
            begin
                cmd.init      = 1'b1;
                cmd.save_back = pass_reg;
                state_next    = S_FETCH;
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                cmd.compare = 1'b1;
                if (status.backtrack)
                    state_next = S_FETCH;
                else if (status.last_step)
                begin
                    if (!pass_reg)
                    begin
                        pass_next  = 1'b1;
                        state_next = S_INIT;
                    end
                    else
                        state_next = S_EMIT;
                end
                else
                    state_next = S_FETCH;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pass_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
        end
    end

endmodule

### rtl/spc_datapath.sv
`timescale 1ns / 1ps

module spc_datapath
    import spc_pkg::*;
#(
    parameter int MAX_LEN = SPC_MAX_LEN
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [CHAR_W-1:0]   char_in,
    input  logic                last_char,
    input  spc_cmd_t            cmd,
    output spc_status_t         status,
    input  logic                out_stall,
    output logic                out_valid,
    output logic [COUNT_W-1:0]  added_count,
    output logic                front_ok,
    output logic                back_ok,
    output logic                overflow
);

    localparam int LEN_W  = $clog2(MAX_LEN + 1);
    localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int PT_D   = 2 * MAX_LEN + 1;
    localparam int IDX_W  = $clog2(PT_D);

    logic [CHAR_W-1:0] store_mem [MAX_LEN];
    logic [IDX_W-1:0]  pt_mem    [PT_D];

    logic [LEN_W-1:0]  len_reg;
    logic              too_long_reg;
    logic [LEN_W-1:0]  n_reg;
    logic              ovf_res_reg;
    logic [IDX_W-1:0]  q_reg;
    logic [IDX_W-1:0]  m_reg;
    logic [IDX_W:0]    back_reg;

    logic [CHAR_W-1:0] rd_q_reg, rd_m_reg;
    logic              sep_q_reg, sep_m_reg;
    logic [IDX_W-1:0]  pt_rd_reg;

    logic              out_valid_reg;
    logic [COUNT_W-1:0] added_reg;
    logic              front_reg, back_ok_reg, ovf_reg;

    logic              too_long_now;
    logic [CHAR_W-1:0] sym_q, sym_m;
    logic              match;
    logic [IDX_W:0]    front_diff;
    logic [IDX_W-1:0]  m_plus;
    logic [IDX_W-1:0]  pt_rd_idx;

    // Map a position of the virtual sequence onto a store address.
    function automatic logic [ADDR_W-1:0] sym_addr(input logic [IDX_W-1:0] i,
                                                   input logic [LEN_W-1:0] n,
                                                   input logic rev);
        logic [IDX_W:0] ie;
        logic [IDX_W:0] ne;
        logic [IDX_W:0] a;
        ie = {1'b0, i};
        ne = (IDX_W + 1)'(n);
        if (ie < ne)
            a = rev ? (ne - ie - 1'b1) : ie;
        else
            a = rev ? (ie - ne - 1'b1) : ((ne << 1) - ie);
        return a[ADDR_W-1:0];
    endfunction

    assign too_long_now = too_long_reg || (len_reg == LEN_W'(MAX_LEN));

    assign sym_q      = sep_q_reg ? SEPARATOR : rd_q_reg;
    assign sym_m      = sep_m_reg ? SEPARATOR : rd_m_reg;
    assign match      = (sym_q == sym_m);
    assign m_plus     = m_reg + IDX_W'(match);
    assign front_diff = (IDX_W + 1)'(n_reg) - {1'b0, m_reg};
    assign pt_rd_idx  = (m_reg == '0) ? '0 : (m_reg - 1'b1);

    assign status.too_long  = too_long_now;
    assign status.backtrack = (m_reg != '0) && !match;
    assign status.last_step = (q_reg == IDX_W'({n_reg, 1'b0}));
    assign status.out_free  = !out_valid_reg || !out_stall;

    // string store: write on load, two registered reads on fetch
    always_ff @(posedge clk)
    begin
        if (cmd.load && (len_reg != LEN_W'(MAX_LEN)))
            store_mem[len_reg[ADDR_W-1:0]] <= char_in;
        if (cmd.fetch)
        begin
            rd_q_reg <= store_mem[sym_addr(q_reg, n_reg, cmd.rev_first)];
            rd_m_reg <= store_mem[sym_addr(m_reg, n_reg, cmd.rev_first)];
        end
    end

    // prefix table: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.init)
            pt_mem[0] <= '0;
        else if (cmd.compare && !status.backtrack)
            pt_mem[q_reg] <= m_plus;
        if (cmd.fetch)
            pt_rd_reg <= pt_mem[pt_rd_idx];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fetch)
        begin
            sep_q_reg <= (q_reg == IDX_W'(n_reg));
            sep_m_reg <= (m_reg == IDX_W'(n_reg));
        end
    end

    // load side: length, overflow, end of string
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg      <= '0;
            too_long_reg <= 1'b0;
            n_reg        <= '0;
            ovf_res_reg  <= 1'b0;
        end
        else if (cmd.load)
        begin
            if (last_char)
            begin
                n_reg        <= too_long_now ? len_reg : (len_reg + 1'b1);
                ovf_res_reg  <= too_long_now;
                len_reg      <= '0;
                too_long_reg <= 1'b0;
            end
            else if (too_long_now)
                too_long_reg <= 1'b1;
            else
                len_reg <= len_reg + 1'b1;
        end
    end

    // pass counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg    <= '0;
            m_reg    <= '0;
            back_reg <= '0;
        end
        else
        begin
            if (cmd.save_back)
                back_reg <= front_diff;
            if (cmd.init)
            begin
                m_reg <= '0;
                q_reg <= IDX_W'(1);
            end
            else if (cmd.compare)
            begin
                if (status.backtrack)
                    m_reg <= pt_rd_reg;
                else
                begin
                    m_reg <= m_plus;
                    q_reg <= q_reg + 1'b1;
                end
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            if (ovf_res_reg)
            begin
                added_reg   <= '0;
                front_reg   <= 1'b0;
                back_ok_reg <= 1'b0;
                ovf_reg     <= 1'b1;
            end
            else
            begin
                ovf_reg <= 1'b0;
                if (front_diff == back_reg)
                begin
                    added_reg   <= COUNT_W'($signed(front_diff));
                    front_reg   <= 1'b1;
                    back_ok_reg <= (front_diff != '0);
                end
                else if (front_diff < back_reg)
                begin
                    added_reg   <= COUNT_W'($signed(front_diff));
                    front_reg   <= 1'b1;
                    back_ok_reg <= 1'b0;
                end
                else
                begin
                    added_reg   <= COUNT_W'($signed(back_reg));
                    front_reg   <= 1'b0;
                    back_ok_reg <= 1'b1;
                end
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign added_count = added_reg;
    assign front_ok    = front_reg;
    assign back_ok     = back_ok_reg;
    assign overflow    = ovf_reg;

    a_match_below_q: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.compare |-> (m_reg < q_reg))
        else $error("match length reached the scan position");

    a_q_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fetch |-> (q_reg <= IDX_W'({n_reg, 1'b0})) && (q_reg != '0))
        else $error("scan position outside the sequence");

    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid_reg)
        else $error("result not presented after emit");

    a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || !out_stall))
        else $error("result overwritten while stalled");

endmodule

### rtl/shortest_palindrome_completion.sv
`timescale 1ns / 1ps

// Shortest palindrome completion. Send the string one byte per word on the
// input channel and raise last_char on its final byte. The final byte starts
// two prefix-function passes over the sequences reverse(s),7,s and
// s,7,reverse(s), each 2n+1 symbols long for a string of n bytes. Each pass
// has a setup state and then steps, each a fetch from the string store and
// prefix table followed by a compare. A step either advances the scan or
// falls back along the prefix table, and a pass makes 2n advances and at most
// 2n fall-backs. Input is stalled from the final byte until the result is in
// the output register; a result waiting there does not block the loading of
// the next string. The result word carries the smaller of the front and back
// counts (counts are taken modulo 2^13) and flags for the side or sides that
// reach it; an already palindromic string reports only the front form. Bytes
// beyond MAX_LEN are dropped, no passes are run, and the result word then
// carries overflow with all other fields zero.

module shortest_palindrome_completion
    import spc_pkg::*;
#(
    parameter int MAX_LEN = SPC_MAX_LEN
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [CHAR_W-1:0]  char_in,
    input  logic               last_char,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [COUNT_W-1:0] added_count,
    output logic               front_ok,
    output logic               back_ok,
    output logic               overflow
);

    spc_cmd_t    cmd;
    spc_status_t status;

    // sequencer: load, two passes, emit
    spc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last_char (last_char),
        .in_stall  (in_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // string store, prefix table, counters and the result register
    spc_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_in     (char_in),
        .last_char   (last_char),
        .cmd         (cmd),
        .status      (status),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .added_count (added_count),
        .front_ok    (front_ok),
        .back_ok     (back_ok),
        .overflow    (overflow)
    );

endmodule
